FILE: src/modexp_right_to_left_binary_top_assert.svh
// assertion macros shared by the modexp checker
// expects clk and rst to be visible where a macro is used
`ifndef MODEXP_RIGHT_TO_LEFT_BINARY_TOP_ASSERT_SVH
`define MODEXP_RIGHT_TO_LEFT_BINARY_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define MEXP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("modexp same-cycle check failed");

// next-cycle implication, quiet during reset
`define MEXP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("modexp next-cycle check failed");

`endif

FILE: src/mexp_pkg.sv
// shared types for the right-to-left binary modular exponentiation block
// no dependencies
package mexp_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } state_t;

endpackage

FILE: src/modexp_right_to_left_binary_top.sv
// Modular exponentiation base^exponent mod modulus, right-to-left square-and-multiply.
// One shared modular multiply-add step unit under a small sequencer. Depends on mexp_pkg.
//
// Usage: present operands with start while busy is low; the item is taken at that edge and
// busy stays high until the result has been shown. The result is on power_result and
// zero_modulus_error, marked by done for exactly one cycle, and cannot be held off; the
// outputs hold until the next item is taken. A zero modulus or a zero exponent shows done in
// the cycle right after start. Otherwise the base is first reduced by the modulus; then for
// each exponent bit up to the highest set bit, a multiply into the accumulator runs when the
// bit is set, followed by a squaring of the base, and done follows in the cycle after the last
// squaring. busy drops the cycle after done, so a new item is taken only once the last result
// has been shown. The step unit handles one multiplier bit per cycle.
// A zero exponent returns 1 even when the modulus is 1; a zero modulus returns 0 with
// zero_modulus_error set.
module modexp_right_to_left_binary_top #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [WIDTH-1:0] base_value,
  input  logic [WIDTH-1:0] exponent_value,
  input  logic [WIDTH-1:0] modulus_value,
  output logic             done,
  output logic [WIDTH-1:0] power_result,
  output logic             zero_modulus_error
);
  import mexp_pkg::*;

  localparam int CW = $clog2(WIDTH);
  localparam int TW = WIDTH + 2;

  state_t state, state_next;

  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] r;
  logic [WIDTH-1:0] ysh;
  logic [WIDTH-1:0] base_r;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] expo;
  logic [WIDTH-1:0] modulus;
  logic [WIDTH-1:0] res;
  logic             err;

  logic             last;
  logic             accept;
  logic             step_en;
  logic             reducing;
  logic             load_op;
  logic [WIDTH-1:0] load_val;

  logic [WIDTH-1:0] addend;
  logic [TW-1:0]    t;
  logic [TW:0]      s1, s2;
  logic [WIDTH-1:0] step_out;

  assign last   = (cnt == '0);
  assign accept = start && (state == ST_IDLE);

  // step unit: r <- (2r + bit*x) mod m, with r < m so the sum stays below 3m
  always_comb begin
    if (reducing) begin
      addend = {{(WIDTH-1){1'b0}}, ysh[WIDTH-1]};
    end else begin
      addend = ysh[WIDTH-1] ? base_r : '0;
    end
    t  = {1'b0, r, 1'b0} + {2'b00, addend};
    s1 = {1'b0, t} - {3'b000, modulus};
    s2 = {1'b0, t} - {2'b00, modulus, 1'b0};
    if (!s2[TW]) begin
      step_out = s2[WIDTH-1:0];
    end else if (!s1[TW]) begin
      step_out = s1[WIDTH-1:0];
    end else begin
      step_out = t[WIDTH-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (modulus_value == '0 || exponent_value == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (last) begin
          state_next = expo[0] ? ST_MUL : ST_SQR;
        end
      end
      ST_MUL: begin
        if (last) begin
          state_next = ST_SQR;
        end
      end
      ST_SQR: begin
        if (last) begin
          if ((expo >> 1) == '0) begin
            state_next = ST_DONE;
          end else begin
            state_next = expo[1] ? ST_MUL : ST_SQR;
          end
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    busy     = 1'b1;
    done     = 1'b0;
    step_en  = 1'b0;
    reducing = 1'b0;
    load_op  = 1'b0;
    load_val = base_r;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        load_op  = start;
        load_val = base_value;
      end
      ST_REDUCE, ST_SQR: begin
        step_en  = 1'b1;
        reducing = (state == ST_REDUCE);
        load_op  = last;
        // the op ending now rewrites the running base
        load_val = (state_next == ST_MUL) ? acc : step_out;
      end
      ST_MUL: begin
        step_en  = 1'b1;
        load_op  = last;
        load_val = base_r;
      end
      ST_DONE: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      expo    <= exponent_value;
      modulus <= modulus_value;
      acc     <= {{(WIDTH-1){1'b0}}, 1'b1};
      err     <= (modulus_value == '0);
      if (modulus_value == '0) begin
        res <= '0;
      end else begin
        res <= {{(WIDTH-1){1'b0}}, 1'b1};
      end
    end
    if (load_op) begin
      r   <= '0;
      ysh <= load_val;
      cnt <= CW'(WIDTH - 1);
    end else if (step_en) begin
      r   <= step_out;
      ysh <= ysh << 1;
      cnt <= cnt - 1'b1;
    end
    if (step_en && last) begin
      case (state)
        ST_MUL: begin
          acc <= step_out;
        end
        ST_REDUCE: begin
          base_r <= step_out;
        end
        ST_SQR: begin
          base_r <= step_out;
          expo   <= expo >> 1;
          if ((expo >> 1) == '0) begin
            res <= acc;
          end
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

  assign power_result       = res;
  assign zero_modulus_error = err;

endmodule

FILE: src/mexp_checker.sv
// port-level checks for modexp_right_to_left_binary_top, bound to the top level
// depends on modexp_right_to_left_binary_top_assert.svh
`include "modexp_right_to_left_binary_top_assert.svh"

module mexp_checker #(
  parameter int WIDTH = 64
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [WIDTH-1:0] power_result,
  input logic             zero_modulus_error
);

  // a result only appears while an item is in flight
  `MEXP_ASSERT_NOW(a_done_while_busy, done, busy)

  // a taken item keeps the block busy
  `MEXP_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy)

  // one strobe per item, then the block is free again
  `MEXP_ASSERT_NEXT(a_done_then_idle, done, !done && !busy)

  // error results carry zero
  `MEXP_ASSERT_NOW(a_err_zero, done && zero_modulus_error, power_result == '0)

endmodule

bind modexp_right_to_left_binary_top mexp_checker #(.WIDTH(WIDTH)) u_mexp_checker (.*);

FILE: sim/modexp_right_to_left_binary_top_tb.sv
`timescale 1ns / 1ps
// testbench for modexp_right_to_left_binary_top: directed corner items, then random items
// checked against a square-and-multiply predictor built on 128-bit products; needs only the rtl
module modexp_right_to_left_binary_top_tb;

  localparam int WIDTH       = 64;
  localparam int STALL_LIMIT = 40000;
  localparam int RANDOM_ITEMS = 80;

  typedef struct {
    logic [WIDTH-1:0] base;
    logic [WIDTH-1:0] expo;
    logic [WIDTH-1:0] modv;
    int               hold_off;
  } operand_t;

  typedef struct {
    logic [WIDTH-1:0] power;
    logic             bad_mod;
  } power_rec_t;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [WIDTH-1:0] base_value;
  logic [WIDTH-1:0] exponent_value;
  logic [WIDTH-1:0] modulus_value;
  logic             done;
  logic [WIDTH-1:0] power_result;
  logic             zero_modulus_error;

  operand_t   operand_queue[$];
  power_rec_t pending_powers[$];
  logic       took_item;
  int         idle_wait;
  int         stall_cycles;
  int         taken_count;
  int         total_items;
  int         errors;

  modexp_right_to_left_binary_top #(.WIDTH(WIDTH)) dut (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .base_value         (base_value),
    .exponent_value     (exponent_value),
    .modulus_value      (modulus_value),
    .done               (done),
    .power_result       (power_result),
    .zero_modulus_error (zero_modulus_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // right-to-left square-and-multiply, products kept exact at double width
  function automatic power_rec_t predict_power(input logic [WIDTH-1:0] b,
                                               input logic [WIDTH-1:0] e,
                                               input logic [WIDTH-1:0] m);
    power_rec_t         rec;
    logic [2*WIDTH-1:0] prod;
    logic [WIDTH-1:0]   acc;
    logic [WIDTH-1:0]   sq;
    logic [WIDTH-1:0]   bits;
    rec.bad_mod = 1'b0;
    if (m == '0) begin
      rec.power   = '0;
      rec.bad_mod = 1'b1;
      return rec;
    end
    acc  = {{(WIDTH-1){1'b0}}, 1'b1};
    sq   = b % m;
    bits = e;
    while (bits != '0) begin
      if (bits[0]) begin
        prod = (2*WIDTH)'(acc) * (2*WIDTH)'(sq);
        acc  = WIDTH'(prod % (2*WIDTH)'(m));
      end
      prod = (2*WIDTH)'(sq) * (2*WIDTH)'(sq);
      sq   = WIDTH'(prod % (2*WIDTH)'(m));
      bits = bits >> 1;
    end
    rec.power = acc;
    return rec;
  endfunction

  function automatic logic [WIDTH-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic void add_item(input logic [WIDTH-1:0] b, input logic [WIDTH-1:0] e,
                                   input logic [WIDTH-1:0] m, input int hold);
    operand_t op;
    op.base     = b;
    op.expo     = e;
    op.modv     = m;
    op.hold_off = hold;
    operand_queue.push_back(op);
  endfunction

  // driver: next item goes out once its hold-off has run while the block is free;
  // a zero hold-off raises start right away and keeps it up until busy drops
  always @(negedge clk) begin : feed_blk
    logic go;
    go = 1'b0;
    if (!rst && !(start && !took_item)) begin
      if (operand_queue.size() != 0 && idle_wait >= operand_queue[0].hold_off) go = 1'b1;
      else if (!busy && idle_wait < 64) idle_wait <= idle_wait + 1;
      if (go) begin
        base_value     <= operand_queue[0].base;
        exponent_value <= operand_queue[0].expo;
        modulus_value  <= operand_queue[0].modv;
        operand_queue.pop_front();
        idle_wait <= 0;
      end
      start <= go;
    end
  end

  // monitor: check results against the oldest prediction, then log new items
  always @(posedge clk) begin : watch_blk
    power_rec_t want;
    logic       accepted;
    accepted = start && !busy;
    if (rst) begin
      took_item    <= 1'b0;
      stall_cycles <= 0;
    end else begin
      took_item <= accepted;
      if (done) begin
        if (pending_powers.size() == 0) begin
          $error("result with no item outstanding: power_result %h zero_modulus_error %b",
                 power_result, zero_modulus_error);
          errors++;
        end else begin
          want = pending_powers.pop_front();
          if (power_result !== want.power) begin
            $error("power_result: expected %h, got %h", want.power, power_result);
            errors++;
          end
          if (zero_modulus_error !== want.bad_mod) begin
            $error("zero_modulus_error: expected %b, got %b", want.bad_mod, zero_modulus_error);
            errors++;
          end
        end
      end
      if (accepted) begin
        pending_powers.push_back(predict_power(base_value, exponent_value, modulus_value));
        taken_count++;
      end
      if (done || accepted) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("modexp_right_to_left_binary_top_tb: errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] e;
    logic [WIDTH-1:0] m;
    logic             burst;
    int               hold;
    rst            = 1'b1;
    start          = 1'b0;
    base_value     = '0;
    exponent_value = '0;
    modulus_value  = '0;
    idle_wait      = 0;
    taken_count    = 0;
    errors         = 0;
    burst          = 1'b0;

    // zero modulus, with and without a zero exponent
    add_item('0, '0, '0, $urandom_range(0, 18));
    add_item('1, '1, '0, $urandom_range(0, 18));
    add_item('1, '0, '0, 0);
    // zero exponent stays 1 even for modulus 1
    add_item(64'd5, '0, 64'd1, $urandom_range(0, 18));
    add_item('1, '0, '1, 0);
    add_item(64'd7, 64'd1, 64'd1, $urandom_range(0, 18));
    add_item('0, 64'd5, 64'd13, $urandom_range(0, 18));
    add_item('1, '1, '1, 0);
    add_item('1, '1, '1 - 64'd1, $urandom_range(0, 18));
    add_item(64'd2, 64'd10, 64'd1000, 0);
    add_item(64'd3, '1, 64'd2, $urandom_range(0, 18));
    // base above the modulus is reduced first
    add_item('1, 64'd2, 64'hFFFF_FFFF_FFFF_FFC5, $urandom_range(0, 18));
    add_item(64'd100, 64'd1, 64'd7, 0);
    add_item(64'd1, 64'h8000_0000_0000_0000, '1, $urandom_range(0, 18));
    add_item(64'd2, 64'h8000_0000_0000_0001, rand_word(), $urandom_range(0, 18));
    add_item(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 64'hFFFF_FFFF_FFFF_FFC5, 0);
    add_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 64'h8000_0000_0000_0000,
             $urandom_range(0, 18));
    add_item(64'd12345, 64'd3, 64'd3, $urandom_range(0, 18));
    add_item(rand_word(), 64'd1, rand_word(), 0);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 10 == 0) burst = ($urandom_range(0, 3) == 0);
      b = rand_word();
      e = rand_word();
      m = rand_word();
      case ($urandom_range(0, 9))
        0: m = 64'($urandom_range(1, 15));
        1: m = '0;
        2: m = '1;
        default: ;
      endcase
      // mostly short exponents to keep the run time down, a few full width
      case ($urandom_range(0, 7))
        0: e = '0;
        1: ;
        default: e = e >> $urandom_range(8, 63);
      endcase
      case ($urandom_range(0, 7))
        0: b = '0;
        1: b = '1;
        2: b = m + 64'($urandom_range(0, 3));
        default: ;
      endcase
      hold = burst ? 0 : $urandom_range(0, 18);
      add_item(b, e, m, hold);
    end
    total_items = operand_queue.size();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (taken_count < total_items || pending_powers.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("modexp_right_to_left_binary_top_tb: clean");
    end else begin
      $display("modexp_right_to_left_binary_top_tb: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/mexp_pkg.sv
src/modexp_right_to_left_binary_top.sv
src/mexp_checker.sv
sim/modexp_right_to_left_binary_top_tb.sv
